// File: rtl/core/glmd_pkg.sv
// shared types, constants and helpers of the grid local minimum detector
package glmd_pkg;

  localparam int MAX_WIDTH = 128;
  localparam int MAX_ROWS  = 128;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int H_W       = 4;
  localparam int RISK_W    = 18;
  localparam int CFG_W     = 8;
  localparam int IDX_W     = 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [H_W-1:0]    OUTSIDE   = H_W'(10);
  localparam logic [H_W-1:0]    H_MAX     = H_W'(9);
  localparam logic [RISK_W-1:0] RISK_MAX  = {RISK_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = IDX_W'(1);

  typedef struct packed {
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
  } limits_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [H_W-1:0]   height;
    logic             low;
  } dec_t;

  // up to three decisions, packed from slot 0, last_idx marks the final one
  typedef struct packed {
    dec_t [2:0]  dec;
    logic [1:0]  last_idx;
    logic        done;
  } job_t;

  function automatic logic [COL_W-1:0] col_limit(input logic [CFG_W-1:0] v);
    logic [COL_W-1:0] res;
    if (v == '0) res = '0;
    else if (32'(v) > MAX_WIDTH) res = COL_W'(MAX_WIDTH - 1);
    else res = COL_W'(v - CFG_W'(1));
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] row_limit(input logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (v == '0) res = '0;
    else if (32'(v) > MAX_ROWS) res = ROW_W'(MAX_ROWS - 1);
    else res = ROW_W'(v - CFG_W'(1));
    return res;
  endfunction

endpackage

// File: rtl/core/glmd_ram.sv
// generic dual read port ram with registered read data
module glmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/glmd_front.sv
// front end: accepts cells, tracks position, keeps the line store, classifies decisions
module glmd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     restart,
  input  glmd_pkg::limits_t        lim,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [glmd_pkg::H_W-1:0] in_height,
  input  logic                     q_full,
  output logic                     push,
  output glmd_pkg::job_t           push_job
);
  import glmd_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [H_W-1:0]   h1_r, h2_r, pmid_r;
  logic [2*H_W-1:0] wdata_r;
  logic             byp_a_r, byp_b_r;
  logic [2*H_W-1:0] rd_a, rd_b, word_a, word_b, wdata;
  logic [COL_W-1:0] raddr_b;
  logic             acc;
  logic [H_W-1:0]   hc, mid, up2, rgt;
  logic             last_row, row_end, va, vl, vs;
  dec_t             d_above, d_left, d_self;
  logic [1:0]       n_dec;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign hc       = (in_height > H_MAX) ? H_MAX : in_height;
  assign last_row = (row_r == lim.row_last);
  assign row_end  = (col_r == lim.col_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (last_row && row_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // each word holds {row r-2, row r-1} for one column; read for the next position
  assign raddr_b = col_nxt + COL_W'(1);
  assign wdata   = {mid, hc};

  glmd_ram #(
    .WIDTH(2 * H_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (acc),
    .waddr   (col_r),
    .wdata   (wdata),
    .raddr_a (col_nxt),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // narrow rows read back a column written in the same cycle
  assign word_a = byp_a_r ? wdata_r : rd_a;
  assign word_b = byp_b_r ? wdata_r : rd_b;
  assign mid    = word_a[H_W-1:0];
  assign up2    = word_a[2*H_W-1:H_W];
  assign rgt    = word_b[H_W-1:0];

  always_comb begin
    logic [H_W-1:0] up, lf, rt;
    up = (row_r >= ROW_W'(2)) ? up2 : OUTSIDE;
    lf = (col_r != '0) ? pmid_r : OUTSIDE;
    rt = (col_r < lim.col_last) ? rgt : OUTSIDE;
    d_above.row    = row_r - ROW_W'(1);
    d_above.col    = col_r;
    d_above.height = mid;
    d_above.low    = (mid < up) && (mid < lf) && (mid < rt) && (mid < hc);

    up = (row_r != '0) ? pmid_r : OUTSIDE;
    lf = (col_r >= COL_W'(2)) ? h2_r : OUTSIDE;
    d_left.row    = row_r;
    d_left.col    = col_r - COL_W'(1);
    d_left.height = h1_r;
    d_left.low    = (h1_r < up) && (h1_r < lf) && (h1_r < hc);

    up = (row_r != '0) ? mid : OUTSIDE;
    lf = (col_r != '0) ? h1_r : OUTSIDE;
    d_self.row    = row_r;
    d_self.col    = col_r;
    d_self.height = hc;
    d_self.low    = (hc < up) && (hc < lf);
  end

  assign va = (row_r != '0);
  assign vl = last_row && (col_r != '0);
  assign vs = last_row && row_end;

  always_comb begin
    n_dec = 2'(va) + 2'(vl) + 2'(vs);
    push_job.dec[2] = d_self;
    push_job.dec[1] = va ? (vl ? d_left : d_self) : d_self;
    push_job.dec[0] = va ? d_above : (vl ? d_left : d_self);
    push_job.last_idx = n_dec - 2'd1;
    push_job.done = vs;
  end

  assign push = acc && (n_dec != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      byp_a_r <= acc && (col_nxt == col_r);
      byp_b_r <= acc && (raddr_b == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      wdata_r <= wdata;
      pmid_r  <= mid;
      h1_r    <= hc;
      h2_r    <= h1_r;
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= lim.col_last || $past(restart))
    else $error("column beyond row width");
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= lim.row_last || $past(restart))
    else $error("row beyond row count");
  a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

endmodule

// File: rtl/core/glmd_queue.sv
// short queue of decision jobs between front and back
module glmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  glmd_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output glmd_pkg::job_t head_job,
  input  logic           pop
);
  import glmd_pkg::*;

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == QCNT_W'(QDEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with count");

endmodule

// File: rtl/core/glmd_back.sv
// back end: sends job decisions one per cycle with out_ready, keeps the risk total
module glmd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        restart,
  input  logic                        head_valid,
  input  glmd_pkg::job_t              head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output glmd_pkg::dec_t              out_dec,
  output logic [glmd_pkg::RISK_W-1:0] out_risk,
  output logic                        out_done,
  output logic                        out_last
);
  import glmd_pkg::*;

  logic [1:0]        sel_r;
  logic [RISK_W-1:0] risk_r;
  logic [RISK_W:0]   risk_sum;
  logic              acc;

  assign out_valid = head_valid;
  assign out_dec   = head_job.dec[sel_r];
  assign out_last  = (sel_r == head_job.last_idx);
  assign out_done  = head_job.done && out_last;
  assign acc       = out_valid && out_ready;
  assign pop       = acc && out_last;

  // saturating add of height plus one on a low point
  assign risk_sum = {1'b0, risk_r}
                  + (out_dec.low ? (RISK_W + 1)'(out_dec.height) + (RISK_W + 1)'(1)
                                 : (RISK_W + 1)'(0));
  assign out_risk = risk_sum[RISK_W] ? RISK_MAX : risk_sum[RISK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r  <= '0;
      risk_r <= '0;
    end else if (restart) begin
      sel_r  <= '0;
      risk_r <= '0;
    end else if (acc) begin
      sel_r  <= out_last ? 2'd0 : sel_r + 2'd1;
      risk_r <= out_done ? '0 : out_risk;
    end
  end

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_last)
    else $error("frame end not on last result");
  a_risk_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc && out_done |=> risk_r == '0)
    else $error("risk total not cleared after frame end");
  a_sel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> sel_r <= head_job.last_idx)
    else $error("decision index beyond job");

endmodule

// File: rtl/core/grid_local_minimum_detector.sv
// top level of the grid local minimum detector
// a decision is registered in the job queue when the cell that causes it is accepted
// throughput: one cell per cycle while the queue has room; a last-row cell past column 0
//   causes two decisions, three at the row end, and the single result port sends one per
//   cycle while out_tready is high, so the four-entry job queue fills and input stalls
// reset: position, queue and risk total clear, both size registers return to 100; the
//   line store is not cleared, every used read hits a column written earlier this frame
module grid_local_minimum_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] cell_height
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [6:0] cell_row, [13:7] cell_col,
                                  // [17:14] decided_height, [18] is_low,
                                  // [36:19] risk_total
  output logic [0:0]  out_tuser,  // [0] frame_done
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import glmd_pkg::*;

  logic [CFG_W-1:0]  row_width_r, row_count_r;
  logic              cfg_acc, restart;
  limits_t           lim;
  logic              q_full, push, head_valid, pop;
  job_t              push_job, head_job;
  dec_t              out_dec;
  logic [RISK_W-1:0] out_risk;
  logic              out_done;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign restart   = cfg_acc && (cfg_index == REG_ROW_WIDTH || cfg_index == REG_ROW_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= CFG_W'(100);
      row_count_r <= CFG_W'(100);
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width_r <= cfg_data;
        REG_ROW_COUNT: row_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lim.col_last = col_limit(row_width_r);
  assign lim.row_last = row_limit(row_count_r);

  glmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .lim       (lim),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_height (in_tdata[H_W-1:0]),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  glmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  glmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (restart),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_dec    (out_dec),
    .out_risk   (out_risk),
    .out_done   (out_done),
    .out_last   (out_tlast)
  );

  assign out_tdata = {3'b000, out_risk, out_dec.low, out_dec.height, out_dec.col, out_dec.row};
  assign out_tuser = out_done;

endmodule
